>>> hw/rtl/ffed_pkg.sv
// Shared types, constants and helpers for the form field extract/decode block.
// No dependencies; imported by every module of the block except ffed_cell.
package ffed_pkg;

    localparam int KEY_MAX_DEF   = 8;
    localparam int RAW_LIMIT_DEF = 192;

    localparam int KEY_W      = 64;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int KLEN_CFG_W = 4;
    localparam int OLIM_W     = 8;

    localparam logic [KLEN_CFG_W-1:0] KEY_LEN_RST   = 4'd4;
    localparam logic [OLIM_W-1:0]     OUT_LIMIT_RST = 8'd96;

    // most result words one body byte can cause: three decoded bytes and the done word
    localparam int MAX_RES = 4;
    localparam int CAND_N  = 5;
    localparam int Q_DEPTH = 8;
    localparam int QAW     = $clog2(Q_DEPTH);
    localparam int QCW     = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_CHARS  = 2'd0,
        CFG_KEY_LENGTH = 2'd1,
        CFG_OUT_LIMIT  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_EQUALS = 2'd1,
        PH_VALUE  = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_PCT  = 2'd1,
        ESC_HEX1 = 2'd2
    } t_esc;

    typedef logic [2:0] t_cnt;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       found;
        logic       done_res;
    } t_result;

    typedef struct packed {
        logic hit;
        logic amp_before;
    } t_win;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_nib(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end else begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

endpackage

>>> hw/rtl/form_field_extract_decode.sv
// Form field extract/decode: one body byte per cycle in while o_stall is low,
// one result word per cycle out while i_stall is low, via a register queue.
// A byte is taken every cycle while the result queue has room for four words;
// bytes causing several words are paced by the one-word-per-cycle output.
// Synchronous reset restores registers and body state at once.
module form_field_extract_decode #(
    parameter int KEY_MAX   = ffed_pkg::KEY_MAX_DEF,
    parameter int RAW_LIMIT = ffed_pkg::RAW_LIMIT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ffed_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ffed_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [7:0]                      i_body_byte,
    input  logic                            i_body_last,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [7:0]                      o_out_byte,
    output logic                            o_byte_valid,
    output logic                            o_found,
    output logic                            o_done_res
);
    import ffed_pkg::*;

    localparam int KW = $clog2(KEY_MAX + 1);

    logic [KEY_W-1:0]      r_key;
    logic [KLEN_CFG_W-1:0] r_klen;
    logic [OLIM_W-1:0]     r_out_limit;

    logic [KW-1:0] klen;
    logic          acc, q_room, q_valid;
    logic [7:0]    cell_q   [KEY_MAX+1];
    logic [7:0]    cell_key [KEY_MAX+1];
    logic          cell_act [KEY_MAX+1];
    logic [KEY_MAX:0] cell_hit;
    logic [KW-1:0] sel;
    t_win          win;
    t_result       res [MAX_RES];
    t_result       head;
    t_cnt          push_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= '0;
            r_klen      <= KEY_LEN_RST;
            r_out_limit <= OUT_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_KEY_CHARS:  r_key       <= i_cfg_data[KEY_W-1:0];
                CFG_KEY_LENGTH: r_klen      <= i_cfg_data[KLEN_CFG_W-1:0];
                CFG_OUT_LIMIT:  r_out_limit <= i_cfg_data[OLIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_klen == '0) begin
            klen = KW'(1);
        end else if (r_klen > KLEN_CFG_W'(KEY_MAX)) begin
            klen = KW'(KEY_MAX);
        end else begin
            klen = KW'(r_klen);
        end
    end

    assign acc     = i_valid && !o_stall;
    assign o_stall = !q_room;

    // key byte for each cell: cell j lines up with key byte klen-1-j
    always_comb begin
        sel = '0;
        for (int j = 0; j <= KEY_MAX; j++) begin
            cell_act[j] = (KW'(j) < klen);
            sel         = cell_act[j] ? klen - KW'(j) - 1'b1 : '0;
            cell_key[j] = r_key[8*sel +: 8];
        end
    end

    for (genvar j = 0; j <= KEY_MAX; j++) begin : g_cell
        logic [7:0] din;
        if (j == 0) begin : g_head
            assign din = i_body_byte;
        end else begin : g_link
            assign din = cell_q[j-1];
        end
        ffed_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (acc),
            .i_clear  (acc && i_body_last),
            .i_din    (din),
            .i_key    (cell_key[j]),
            .i_active (cell_act[j]),
            .o_q      (cell_q[j]),
            .o_hit    (cell_hit[j])
        );
    end

    assign win.hit        = &cell_hit;
    assign win.amp_before = (cell_q[klen - 1'b1] == CH_AMP);

    ffed_decode #(
        .KEY_MAX   (KEY_MAX),
        .RAW_LIMIT (RAW_LIMIT)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_byte      (i_body_byte),
        .i_last      (i_body_last),
        .i_win       (win),
        .i_klen      (klen),
        .i_out_limit (r_out_limit),
        .o_res       (res),
        .o_push_cnt  (push_cnt)
    );

    ffed_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_data     (res),
        .i_pop      (q_valid && !i_stall),
        .o_head     (head),
        .o_valid    (q_valid),
        .o_room     (q_room)
    );

    assign o_valid      = q_valid;
    assign o_out_byte   = head.out_byte;
    assign o_byte_valid = head.byte_valid;
    assign o_found      = head.found;
    assign o_done_res   = head.done_res;

endmodule

>>> hw/rtl/ffed_cell.sv
// One window cell: holds one recent body byte, passes it on to the next cell
// and compares its incoming byte against its key byte. Depends on nothing.
module ffed_cell (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  logic       i_clear,
    input  logic [7:0] i_din,
    input  logic [7:0] i_key,
    input  logic       i_active,
    output logic [7:0] o_q,
    output logic       o_hit
);
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_clear) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_din;
        end
    end

    assign o_q   = r_q;
    assign o_hit = !i_active || (i_din == i_key);

endmodule

>>> hw/rtl/ffed_decode.sv
// Phase sequencer and URL decoder: key/equals checks, value limits, escapes
// and output limit. Produces up to MAX_RES result words per byte. Uses ffed_pkg.
module ffed_decode #(
    parameter int KEY_MAX   = ffed_pkg::KEY_MAX_DEF,
    parameter int RAW_LIMIT = ffed_pkg::RAW_LIMIT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_acc,
    input  logic [7:0]                        i_byte,
    input  logic                              i_last,
    input  ffed_pkg::t_win                    i_win,
    input  logic [$clog2(KEY_MAX+1)-1:0]      i_klen,
    input  logic [ffed_pkg::OLIM_W-1:0]       i_out_limit,
    output ffed_pkg::t_result                 o_res [ffed_pkg::MAX_RES],
    output ffed_pkg::t_cnt                    o_push_cnt
);
    import ffed_pkg::*;

    localparam int PW = $clog2(KEY_MAX + 2);
    localparam int RW = $clog2(RAW_LIMIT);
    localparam logic [PW-1:0] POS_SAT = PW'(KEY_MAX + 1);

    t_phase        r_phase, n_phase;
    t_esc          r_esc, n_esc;
    logic [7:0]    r_fh, n_fh;
    logic [RW-1:0] r_raw, n_raw;
    logic [PW-1:0] r_pos, n_pos;
    logic [7:0]    r_emit, n_emit;
    logic          r_found, n_found;

    logic          is_amp, in_val, raw_hit, flush_now;
    logic [RW-1:0] raw_inc;
    logic [PW-1:0] klen_ext;

    t_esc          dec_esc, esc_mid;
    logic [7:0]    dec_fh, fh_mid;
    logic [7:0]    d [3];
    logic [1:0]    nd;
    logic          plain;

    logic [7:0]    cand [CAND_N];
    t_cnt          ncand, allowed;
    logic [7:0]    lim1, room;

    assign is_amp   = (i_byte == CH_AMP);
    assign in_val   = (r_phase == PH_VALUE);
    assign raw_inc  = r_raw + 1'b1;
    assign raw_hit  = in_val && !is_amp && (raw_inc >= RW'(RAW_LIMIT - 1));
    assign flush_now = in_val && (is_amp || raw_hit || i_last);
    assign klen_ext = PW'(i_klen);
    assign n_pos    = (r_pos == POS_SAT) ? r_pos : r_pos + 1'b1;

    // byte decode against the pending escape
    always_comb begin
        dec_esc = r_esc;
        dec_fh  = r_fh;
        d       = '{default: '0};
        nd      = '0;
        plain   = 1'b0;
        case (r_esc)
            ESC_PCT: begin
                if (is_hex(i_byte)) begin
                    dec_esc = ESC_HEX1;
                    dec_fh  = i_byte;
                end else begin
                    d[0]  = CH_PCT;
                    nd    = 2'd1;
                    plain = 1'b1;
                end
            end
            ESC_HEX1: begin
                if (is_hex(i_byte)) begin
                    d[0]    = {hex_nib(r_fh), hex_nib(i_byte)};
                    nd      = 2'd1;
                    dec_esc = ESC_NONE;
                end else begin
                    d[0]  = CH_PCT;
                    d[1]  = r_fh;
                    nd    = 2'd2;
                    plain = 1'b1;
                end
            end
            default: plain = 1'b1;
        endcase
        if (plain) begin
            dec_esc = ESC_NONE;
            if (i_byte == CH_PLUS) begin
                d[nd] = CH_SPACE;
                nd    = nd + 1'b1;
            end else if (i_byte == CH_PCT) begin
                dec_esc = ESC_PCT;
            end else begin
                d[nd] = i_byte;
                nd    = nd + 1'b1;
            end
        end
    end

    assign esc_mid = is_amp ? r_esc : dec_esc;
    assign fh_mid  = is_amp ? r_fh : dec_fh;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_esc   = r_esc;
        n_fh    = r_fh;
        n_raw   = r_raw;
        n_found = r_found;
        case (r_phase)
            PH_SEARCH: begin
                if (n_pos >= klen_ext && i_win.hit) begin
                    n_phase = (n_pos == klen_ext || i_win.amp_before) ? PH_EQUALS : PH_DONE;
                end
            end
            PH_EQUALS: begin
                if (i_byte == CH_EQ) begin
                    n_phase = PH_VALUE;
                    n_found = 1'b1;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_VALUE: begin
                n_fh  = fh_mid;
                n_esc = flush_now ? ESC_NONE : esc_mid;
                if (!is_amp) begin
                    n_raw = raw_inc;
                end
                if (is_amp || raw_hit) begin
                    n_phase = PH_DONE;
                end
            end
            default: n_phase = PH_DONE;
        endcase
    end

    // candidate bytes, output limit, result words
    always_comb begin
        cand  = '{default: '0};
        ncand = '0;
        if (in_val && !is_amp) begin
            for (int i = 0; i < 3; i++) begin
                cand[i] = d[i];
            end
            ncand = t_cnt'(nd);
        end
        if (flush_now && esc_mid != ESC_NONE) begin
            cand[ncand] = CH_PCT;
            ncand       = ncand + 1'b1;
            if (esc_mid == ESC_HEX1) begin
                cand[ncand] = fh_mid;
                ncand       = ncand + 1'b1;
            end
        end
        lim1    = i_out_limit - 1'b1;
        room    = (i_out_limit == '0 || r_emit >= lim1) ? '0 : lim1 - r_emit;
        allowed = (room < 8'(ncand)) ? room[2:0] : ncand;
        n_emit  = r_emit + 8'(allowed);
        for (int i = 0; i < MAX_RES; i++) begin
            if (t_cnt'(i) < allowed) begin
                o_res[i] = '{out_byte: cand[i], byte_valid: 1'b1, found: 1'b0, done_res: 1'b0};
            end else begin
                o_res[i] = '{out_byte: 8'h00, byte_valid: 1'b0, found: n_found, done_res: 1'b1};
            end
        end
        o_push_cnt = i_acc ? allowed + t_cnt'(i_last) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_acc && i_last)) begin
            r_phase <= PH_SEARCH;
            r_esc   <= ESC_NONE;
            r_fh    <= '0;
            r_raw   <= '0;
            r_pos   <= '0;
            r_emit  <= '0;
            r_found <= 1'b0;
        end else if (i_acc) begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
            r_fh    <= n_fh;
            r_raw   <= n_raw;
            r_pos   <= n_pos;
            r_emit  <= n_emit;
            r_found <= n_found;
        end
    end

endmodule

>>> hw/rtl/ffed_queue.sv
// Result word queue: takes up to MAX_RES words per cycle, gives one per cycle when popped.
// Register array of Q_DEPTH entries. Uses ffed_pkg.
module ffed_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ffed_pkg::t_cnt    i_push_cnt,
    input  ffed_pkg::t_result i_data [ffed_pkg::MAX_RES],
    input  logic              i_pop,
    output ffed_pkg::t_result o_head,
    output logic              o_valid,
    output logic              o_room
);
    import ffed_pkg::*;

    t_result        r_mem [Q_DEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QCW-1:0] r_cnt;
    logic [QAW-1:0] wr_addr [MAX_RES];

    always_comb begin
        for (int k = 0; k < MAX_RES; k++) begin
            wr_addr[k] = r_wr + QAW'(k);
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_valid = (r_cnt != '0);
    assign o_room  = (r_cnt <= QCW'(Q_DEPTH - MAX_RES));

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (t_cnt'(k) < i_push_cnt) begin
                r_mem[wr_addr[k]] <= i_data[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + QAW'(i_push_cnt);
            r_rd  <= r_rd + QAW'(i_pop);
            r_cnt <= r_cnt + QCW'(i_push_cnt) - QCW'(i_pop);
        end
    end

endmodule

>>> hw/rtl/ffed_checker.sv
// Port-level checks for form_field_extract_decode, bound to the top level.
// Uses ffed_pkg for port widths.
module ffed_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_we,
    input logic [ffed_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [ffed_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input logic                            i_valid,
    input logic                            o_stall,
    input logic [7:0]                      i_body_byte,
    input logic                            i_body_last,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic [7:0]                      o_out_byte,
    input logic                            o_byte_valid,
    input logic                            o_found,
    input logic                            o_done_res
);
    import ffed_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && !o_stall)
        else $error("queue not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_byte_valid)
                               && $stable(o_found) && $stable(o_done_res))
        else $error("stalled output word changed");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_byte_valid != o_done_res))
        else $error("output word is neither byte nor done");

    a_word_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_done_res ? (o_out_byte == 8'h00) : !o_found))
        else $error("output word carries stray fields");

endmodule

bind form_field_extract_decode ffed_checker u_ffed_chk (.*);
